FILE: hw/rtl/msp_pkg.sv
// Package for the multi-channel step-pulse generator.
// Holds request/response structs, opcodes and register indexes; no dependencies.
package msp_pkg;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_START     = 3'd1,
      OP_STOP      = 3'd2,
      OP_PAUSE     = 3'd3,
      OP_RESUME    = 3'd4,
      OP_SET_IVL   = 3'd5,
      OP_SET_MIN   = 3'd6,
      OP_QUERY     = 3'd7
   } opcode_type;

   localparam logic [1:0] REG_MIN_PULSE  = 2'd0;
   localparam logic [1:0] REG_MOTOR_CNT  = 2'd1;
   localparam logic [1:0] REG_AUTOCORR   = 2'd2;

   localparam logic [31:0] DEFAULT_FLOOR  = 32'd20;
   localparam logic [31:0] DEFAULT_MINPW  = 32'd10;
   localparam logic [3:0]  DEFAULT_COUNT  = 4'd8;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  motor;
      logic [31:0] now;
      logic [31:0] interval;
      logic [31:0] step_total;
      logic        finite;
   } req_type;

   typedef struct packed {
      logic [7:0]  step_levels;
      logic [7:0]  running_mask;
      logic        accepted;
      logic        sel_finished;
      logic        sel_paused;
      logic [31:0] sel_remaining;
   } rsp_type;

   // Classified request as it travels from the front end to the back end.
   typedef struct packed {
      req_type     req;
      logic        valid_motor;
      logic        ivl_ok;
   } cmd_type;

endpackage

FILE: hw/rtl/multi_stepper_pulse_generator.sv
// Multi-channel step-pulse generator, top level.
// An accepted request waits in the two-entry queue, is taken into the back end's command
// register and, for a tick, swept over the channels in use by the channel-by-channel
// sequencer before the done state. Enabling autocorrect runs a sweep over the channels.
// Reset is synchronous and restores the configuration registers, queue pointers and channel records.
// The receiver cannot stall; each response strobes for a single cycle.
module multi_stepper_pulse_generator #(
   parameter int MOTORS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  msp_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output msp_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   logic [31:0] min_pw_ff;
   logic [3:0]  count_ff;
   logic        ac_ff, ac_rise_ff, ac_rise_in;
   logic        queue_full, not_empty, push, pop, back_busy;
   msp_pkg::cmd_type push_cmd, head;

   assign csr_ready = 1'b1;
   assign busy      = queue_full || ac_rise_ff;

   // A pending sync request holds until the back end picks it up.
   assign ac_rise_in = (csr_valid && csr_ready && csr_index == msp_pkg::REG_AUTOCORR &&
                        csr_data[0] && !ac_ff) || (ac_rise_ff && back_busy);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pw_ff  <= msp_pkg::DEFAULT_MINPW;
         count_ff   <= msp_pkg::DEFAULT_COUNT;
         ac_ff      <= 1'b0;
         ac_rise_ff <= 1'b0;
      end else begin
         ac_rise_ff <= ac_rise_in;
         if (csr_valid) begin
            case (csr_index)
               msp_pkg::REG_MIN_PULSE: min_pw_ff <= csr_data;
               msp_pkg::REG_MOTOR_CNT: count_ff  <= csr_data[3:0];
               msp_pkg::REG_AUTOCORR:  ac_ff     <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   msp_front #(.MOTORS(MOTORS)) u_front (
      .start, .req_data,
      .chan_limit(count_ff), .pulse_min(min_pw_ff),
      .busy, .push, .push_cmd
   );

   msp_queue u_queue (
      .clock, .reset, .push, .push_cmd, .pop,
      .full(queue_full), .not_empty, .head
   );

   msp_back #(.MOTORS(MOTORS)) u_back (
      .clock, .reset, .not_empty, .head, .pop,
      .pulse_min(min_pw_ff), .chan_limit(count_ff),
      .ac_en(ac_ff), .ac_rise(ac_rise_ff), .busy(back_busy),
      .rsp_strobe, .rsp_data
   );

   accept_room_a: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !queue_full) else $error("accept into full queue");

endmodule

FILE: hw/rtl/msp_front.sv
// Front end of the step-pulse generator: accepts requests and classifies them.
// Depends on msp_pkg.
module msp_front #(
   parameter int MOTORS = 8
) (
   input  logic              start,
   input  msp_pkg::req_type  req_data,
   input  logic [3:0]        chan_limit,
   input  logic [31:0]       pulse_min,
   input  logic              busy,
   output logic              push,
   output msp_pkg::cmd_type  push_cmd
);

   logic [5:0]  eff_count;
   logic [32:0] twice_min;

   // Accept whenever the block is not busy.
   assign push = start && !busy;

   // Saturate the motor count at the number of built channels.
   always_comb begin
      if (32'(chan_limit) > 32'(MOTORS)) begin
         eff_count = 6'(MOTORS);
      end else begin
         eff_count = 6'(chan_limit);
      end
   end

   // Interval must be at least twice the minimum pulse width, without wrap.
   assign twice_min = {pulse_min, 1'b0};

   always_comb begin
      push_cmd.req         = req_data;
      push_cmd.valid_motor = {3'b0, req_data.motor} < eff_count;
      push_cmd.ivl_ok      = {1'b0, req_data.interval} >= twice_min;
   end

endmodule

FILE: hw/rtl/msp_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on msp_pkg.
module msp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msp_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output msp_pkg::cmd_type  head
);

   msp_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = slot_ff[rd_ptr_ff];

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   no_overflow_a: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   no_underflow_a: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue underflow");

endmodule

FILE: hw/rtl/msp_back.sv
// Back end: carries out commands on the per-channel records, one channel a cycle
// for ticks and autocorrect enabling. Depends on msp_pkg.
module msp_back #(
   parameter int MOTORS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              not_empty,
   input  msp_pkg::cmd_type  head,
   output logic              pop,
   input  logic [31:0]       pulse_min,
   input  logic [3:0]        chan_limit,
   input  logic              ac_en,
   input  logic              ac_rise,
   output logic              busy,
   output logic              rsp_strobe,
   output msp_pkg::rsp_type  rsp_data
);

   localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_SYNC,
      ST_DONE
   } state_type;

   state_type   state_ff;
   logic [IW:0] idx_ff;
   msp_pkg::cmd_type cmd_ff;
   logic        acc_ff;

   logic [MOTORS-1:0] active_ff, high_ff, counted_ff;
   logic [31:0] period_ff  [MOTORS];
   logic [31:0] remain_ff  [MOTORS];
   logic [31:0] rise_ff    [MOTORS];
   logic [31:0] fall_ff    [MOTORS];
   logic [31:0] crise_ff   [MOTORS];
   logic [31:0] lag_ff     [MOTORS];
   logic [31:0] floor_ff   [MOTORS];
   logic [31:0] cap_ff     [MOTORS];

   logic [IW:0] eff_count;
   logic [IW-1:0] ti, ci;
   logic [31:0] delta, since_rise, since_fall, lag_new, sat_cap;

   always_comb begin
      if (32'(chan_limit) > 32'(MOTORS)) eff_count = (IW+1)'(MOTORS);
      else eff_count = (IW+1)'(chan_limit);
   end

   assign ti = idx_ff[IW-1:0];
   assign ci = IW'(cmd_ff.req.motor);

   // Tick arithmetic for the visited channel.
   assign delta      = cmd_ff.req.now - (ac_en ? crise_ff[ti] : rise_ff[ti]);
   assign since_rise = cmd_ff.req.now - rise_ff[ti];
   assign since_fall = cmd_ff.req.now - fall_ff[ti];
   assign lag_new    = lag_ff[ti] + (delta - period_ff[ti]);
   assign sat_cap    = (cmd_ff.req.interval >= floor_ff[ci]) ?
                       cmd_ff.req.interval - floor_ff[ci] : 32'd0;

   assign busy = (state_ff != ST_IDLE);
   assign pop  = (state_ff == ST_IDLE) && !ac_rise && not_empty;

   // Sequencer and channel records.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         acc_ff     <= 1'b0;
         active_ff  <= '0;
         high_ff    <= '0;
         counted_ff <= '0;
         for (int i = 0; i < MOTORS; i++) begin
            period_ff[i] <= '0;
            remain_ff[i] <= '0;
            rise_ff[i]   <= '0;
            fall_ff[i]   <= '0;
            crise_ff[i]  <= '0;
            lag_ff[i]    <= '0;
            floor_ff[i]  <= msp_pkg::DEFAULT_FLOOR;
            cap_ff[i]    <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (ac_rise) begin
                  state_ff <= ST_SYNC;
               end else if (not_empty) begin
                  cmd_ff <= head;
                  acc_ff <= 1'b0;
                  if (head.req.opcode == msp_pkg::OP_TICK) state_ff <= ST_TICK;
                  else state_ff <= ST_DONE;
               end
            end
            ST_SYNC: begin
               // Copy rise time into corrected rise for active channels in use.
               if (idx_ff >= eff_count) begin
                  state_ff <= ST_IDLE;
               end else begin
                  if (active_ff[ti]) crise_ff[ti] <= rise_ff[ti];
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_TICK: begin
               if (idx_ff >= eff_count) begin
                  acc_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  if (active_ff[ti]) begin
                     if (high_ff[ti]) begin
                        if (since_rise >= pulse_min) begin
                           high_ff[ti] <= 1'b0;
                           fall_ff[ti] <= cmd_ff.req.now;
                        end
                     end else if (remain_ff[ti] == '0) begin
                        if (since_fall >= pulse_min) active_ff[ti] <= 1'b0;
                     end else if (delta >= period_ff[ti] &&
                                  since_fall >= pulse_min) begin
                        high_ff[ti] <= 1'b1;
                        rise_ff[ti] <= cmd_ff.req.now;
                        if (counted_ff[ti]) remain_ff[ti] <= remain_ff[ti] - 1'b1;
                        if (ac_en) begin
                           if (lag_new > cap_ff[ti]) begin
                              crise_ff[ti] <= cmd_ff.req.now - cap_ff[ti];
                              lag_ff[ti]   <= lag_new - cap_ff[ti];
                           end else begin
                              crise_ff[ti] <= cmd_ff.req.now - lag_new;
                              lag_ff[ti]   <= '0;
                           end
                        end
                     end
                  end
               end
            end
            ST_DONE: begin
               // Apply addressed commands, then issue the response next cycle.
               state_ff <= ST_IDLE;
               if (cmd_ff.req.opcode != msp_pkg::OP_TICK && cmd_ff.valid_motor) begin
                  case (cmd_ff.req.opcode)
                     msp_pkg::OP_START: begin
                        if (cmd_ff.ivl_ok && !(ac_en && cmd_ff.req.interval < floor_ff[ci]))
                        begin
                           lag_ff[ci]     <= '0;
                           cap_ff[ci]     <= sat_cap;
                           crise_ff[ci]   <= cmd_ff.req.now;
                           rise_ff[ci]    <= cmd_ff.req.now;
                           fall_ff[ci]    <= cmd_ff.req.now;
                           high_ff[ci]    <= 1'b0;
                           remain_ff[ci]  <= cmd_ff.req.finite ?
                                             cmd_ff.req.step_total : 32'd1;
                           period_ff[ci]  <= cmd_ff.req.interval;
                           counted_ff[ci] <= cmd_ff.req.finite;
                           active_ff[ci]  <= 1'b1;
                           acc_ff         <= 1'b1;
                        end
                     end
                     msp_pkg::OP_STOP: begin
                        remain_ff[ci] <= '0;
                        acc_ff        <= 1'b1;
                     end
                     msp_pkg::OP_PAUSE: begin
                        active_ff[ci] <= 1'b0;
                        acc_ff        <= 1'b1;
                     end
                     msp_pkg::OP_RESUME: begin
                        rise_ff[ci]   <= cmd_ff.req.now;
                        crise_ff[ci]  <= cmd_ff.req.now;
                        lag_ff[ci]    <= '0;
                        fall_ff[ci]   <= cmd_ff.req.now;
                        active_ff[ci] <= 1'b1;
                        acc_ff        <= 1'b1;
                     end
                     msp_pkg::OP_SET_IVL: begin
                        if (cmd_ff.ivl_ok) begin
                           cap_ff[ci]    <= sat_cap;
                           period_ff[ci] <= cmd_ff.req.interval;
                           acc_ff        <= 1'b1;
                        end
                     end
                     msp_pkg::OP_SET_MIN: begin
                        if (cmd_ff.ivl_ok) begin
                           floor_ff[ci] <= cmd_ff.req.interval;
                           if (ac_en && active_ff[ci] &&
                               period_ff[ci] >= cmd_ff.req.interval) begin
                              cap_ff[ci] <= period_ff[ci] - cmd_ff.req.interval;
                           end
                           acc_ff <= 1'b1;
                        end
                     end
                     default: acc_ff <= 1'b1;
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Response fields are read from the records after the update has landed.
   msp_pkg::cmd_type  rcmd_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else rsp_strobe <= (state_ff == ST_DONE);
      if (state_ff == ST_DONE) rcmd_ff <= cmd_ff;
   end

   always_comb begin
      logic [IW-1:0] ri;
      ri = IW'(rcmd_ff.req.motor);
      rsp_data = '0;
      for (int i = 0; i < MOTORS && i < 8; i++) begin
         rsp_data.step_levels[i]  = high_ff[i];
         rsp_data.running_mask[i] = active_ff[i];
      end
      rsp_data.accepted = acc_ff;
      if (rcmd_ff.valid_motor) begin
         rsp_data.sel_finished  = !active_ff[ri] && remain_ff[ri] == '0;
         rsp_data.sel_paused    = !active_ff[ri] && remain_ff[ri] != '0;
         rsp_data.sel_remaining = remain_ff[ri];
      end
   end

   strobe_one_a: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == ST_IDLE) else $error("response outside idle");
   strobe_after_done_a: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DONE)) else $error("stray response");
   tick_bound_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK |-> idx_ff <= eff_count) else $error("tick index overrun");

endmodule

FILE: tb/testbench.sv
// Testbench for the multi-channel step-pulse generator (multi_stepper_pulse_generator).
// Drives command requests and register writes, and checks each response against a
// built-in predictor. Depends on msp_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;

   localparam int NCH = 8;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 20;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   msp_pkg::req_type  req_data;
   logic              rsp_strobe;
   msp_pkg::rsp_type  rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [31:0]       csr_data;

   multi_stepper_pulse_generator #(.MOTORS(NCH)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the channel records and the registers.
   bit          ch_active [NCH];
   bit          ch_high [NCH];
   bit          ch_counted [NCH];
   logic [31:0] ch_period [NCH];
   logic [31:0] ch_left [NCH];
   logic [31:0] ch_rise [NCH];
   logic [31:0] ch_fall [NCH];
   logic [31:0] ch_crise [NCH];
   logic [31:0] ch_lag [NCH];
   logic [31:0] ch_floor [NCH];
   logic [31:0] ch_cap [NCH];
   logic [31:0] pulse_min;
   logic [3:0]  chan_count;
   bit          lag_fix;

   msp_pkg::rsp_type pending_rsp[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   logic [31:0] clock_now = 0;

   typedef struct {
      msp_pkg::req_type r;
      bit               typed;
      msp_pkg::rsp_type exp;
   } stim_row_type;
   stim_row_type directed_rows[$];

   // Clock and cycle limit.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] sat_diff(logic [31:0] a, logic [31:0] b);
      return (a >= b) ? a - b : 32'd0;
   endfunction

   function automatic bit wide_enough(logic [31:0] iv);
      return {1'b0, iv} >= {pulse_min, 1'b0};
   endfunction

   function automatic int channels_in_use();
      return (chan_count > NCH) ? NCH : int'(chan_count);
   endfunction

   // Advance one channel by a tick at time stamp now.
   function automatic void tick_channel(int i, logic [31:0] now);
      logic [31:0] delta;
      if (!ch_active[i]) return;
      if (ch_high[i]) begin
         if (now - ch_rise[i] >= pulse_min) begin
            ch_high[i] = 0;
            ch_fall[i] = now;
         end
         return;
      end
      if (ch_left[i] == 0) begin
         if (now - ch_fall[i] >= pulse_min) ch_active[i] = 0;
         return;
      end
      delta = now - (lag_fix ? ch_crise[i] : ch_rise[i]);
      if (delta < ch_period[i]) return;
      if (now - ch_fall[i] < pulse_min) return;
      ch_high[i] = 1;
      ch_rise[i] = now;
      if (ch_counted[i]) ch_left[i] = ch_left[i] - 32'd1;
      if (lag_fix) begin
         ch_crise[i] = now;
         ch_lag[i] = ch_lag[i] + (delta - ch_period[i]);
         if (ch_lag[i] > ch_cap[i]) begin
            ch_crise[i] = ch_crise[i] - ch_cap[i];
            ch_lag[i] = ch_lag[i] - ch_cap[i];
         end else begin
            ch_crise[i] = ch_crise[i] - ch_lag[i];
            ch_lag[i] = 0;
         end
      end
   endfunction

   // Apply one command to the shadow state and return the response it yields.
   function automatic msp_pkg::rsp_type step_outcome(msp_pkg::req_type r);
      msp_pkg::rsp_type o;
      int n;
      int m;
      bit ok;
      bit acc;
      n = channels_in_use();
      m = int'(r.motor);
      ok = m < n;
      acc = 0;
      if (msp_pkg::opcode_type'(r.opcode) == msp_pkg::OP_TICK) begin
         for (int i = 0; i < n; i++) tick_channel(i, r.now);
         acc = 1;
      end else if (ok) begin
         case (msp_pkg::opcode_type'(r.opcode))
            msp_pkg::OP_START: begin
               if (wide_enough(r.interval) && !(lag_fix && r.interval < ch_floor[m])) begin
                  ch_lag[m] = 0;
                  ch_cap[m] = sat_diff(r.interval, ch_floor[m]);
                  ch_crise[m] = r.now;
                  ch_rise[m] = r.now;
                  ch_fall[m] = r.now;
                  ch_high[m] = 0;
                  ch_left[m] = r.finite ? r.step_total : 32'd1;
                  ch_period[m] = r.interval;
                  ch_counted[m] = r.finite;
                  ch_active[m] = 1;
                  acc = 1;
               end
            end
            msp_pkg::OP_STOP: begin
               ch_left[m] = 0;
               acc = 1;
            end
            msp_pkg::OP_PAUSE: begin
               ch_active[m] = 0;
               acc = 1;
            end
            msp_pkg::OP_RESUME: begin
               ch_rise[m] = r.now;
               ch_crise[m] = r.now;
               ch_lag[m] = 0;
               ch_fall[m] = r.now;
               ch_active[m] = 1;
               acc = 1;
            end
            msp_pkg::OP_SET_IVL: begin
               if (wide_enough(r.interval)) begin
                  ch_cap[m] = sat_diff(r.interval, ch_floor[m]);
                  ch_period[m] = r.interval;
                  acc = 1;
               end
            end
            msp_pkg::OP_SET_MIN: begin
               if (wide_enough(r.interval)) begin
                  ch_floor[m] = r.interval;
                  if (lag_fix && ch_active[m] && ch_period[m] >= r.interval)
                     ch_cap[m] = ch_period[m] - r.interval;
                  acc = 1;
               end
            end
            default: acc = 1;
         endcase
      end
      for (int i = 0; i < NCH; i++) begin
         o.step_levels[i] = ch_high[i];
         o.running_mask[i] = ch_active[i];
      end
      o.accepted = acc;
      o.sel_finished = ok && !ch_active[m] && ch_left[m] == 0;
      o.sel_paused = ok && !ch_active[m] && ch_left[m] != 0;
      o.sel_remaining = ok ? ch_left[m] : 32'd0;
      return o;
   endfunction

   function automatic void apply_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
         msp_pkg::REG_MIN_PULSE: pulse_min = value;
         msp_pkg::REG_MOTOR_CNT: chan_count = value[3:0];
         msp_pkg::REG_AUTOCORR: begin
            if (value[0] && !lag_fix)
               for (int i = 0; i < channels_in_use(); i++)
                  if (ch_active[i]) ch_crise[i] = ch_rise[i];
            lag_fix = value[0];
         end
         default: ;
      endcase
   endfunction

   // Response checker: every strobe must match the oldest pending response.
   always @(posedge clock) begin
      msp_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.step_levels !== want.step_levels) begin
               $error("step_levels exp %h got %h", want.step_levels, rsp_data.step_levels);
               fail_count++;
            end
            if (rsp_data.running_mask !== want.running_mask) begin
               $error("running_mask exp %h got %h", want.running_mask, rsp_data.running_mask);
               fail_count++;
            end
            if (rsp_data.accepted !== want.accepted) begin
               $error("accepted exp %b got %b", want.accepted, rsp_data.accepted);
               fail_count++;
            end
            if (rsp_data.sel_finished !== want.sel_finished) begin
               $error("sel_finished exp %b got %b", want.sel_finished, rsp_data.sel_finished);
               fail_count++;
            end
            if (rsp_data.sel_paused !== want.sel_paused) begin
               $error("sel_paused exp %b got %b", want.sel_paused, rsp_data.sel_paused);
               fail_count++;
            end
            if (rsp_data.sel_remaining !== want.sel_remaining) begin
               $error("sel_remaining exp %h got %h", want.sel_remaining,
                      rsp_data.sel_remaining);
               fail_count++;
            end
         end
      end
   end

   // Send one request after a gap; start stays high across back-to-back requests.
   task automatic send_request(msp_pkg::req_type r, int gap, bit typed,
                               msp_pkg::rsp_type exp);
      msp_pkg::rsp_type got;
      if (gap > 0) begin
         start = 0;
         repeat (gap) @(negedge clock);
      end
      start = 1;
      req_data = r;
      do @(posedge clock); while (busy);
      got = step_outcome(r);
      pending_rsp.push_back(typed ? exp : got);
      @(negedge clock);
   endtask

   // Wait until every pending response has arrived, then let the block settle.
   task automatic drain();
      start = 0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] value);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, value);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic void add_row(msp_pkg::opcode_type op, int mot, logic [31:0] now,
                                   logic [31:0] iv, logic [31:0] cnt, bit fin,
                                   bit typed = 0, msp_pkg::rsp_type exp = '0);
      stim_row_type s;
      s.r = '{opcode: op, motor: mot[2:0], now: now, interval: iv,
              step_total: cnt, finite: fin};
      s.typed = typed;
      s.exp = exp;
      directed_rows.push_back(s);
   endfunction

   // Random request, ticks most often, on a slowly advancing clock with small intervals.
   function automatic msp_pkg::req_type random_request();
      msp_pkg::req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) r.opcode = msp_pkg::OP_TICK;
      else if (pick < 62) r.opcode = msp_pkg::OP_START;
      else if (pick < 67) r.opcode = msp_pkg::OP_STOP;
      else if (pick < 73) r.opcode = msp_pkg::OP_PAUSE;
      else if (pick < 80) r.opcode = msp_pkg::OP_RESUME;
      else if (pick < 87) r.opcode = msp_pkg::OP_SET_IVL;
      else if (pick < 93) r.opcode = msp_pkg::OP_SET_MIN;
      else r.opcode = msp_pkg::OP_QUERY;
      r.motor = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 3) clock_now = $urandom();
      else clock_now = clock_now + $urandom_range(0, 12);
      r.now = clock_now;
      r.interval = ($urandom_range(0, 99) < 5) ? $urandom() : $urandom_range(0, 80);
      r.step_total = ($urandom_range(0, 99) < 5) ? $urandom() : $urandom_range(0, 6);
      r.finite = 1'($urandom_range(0, 1));
      return r;
   endfunction

   initial begin
      msp_pkg::rsp_type none;
      logic [31:0] pw;
      logic [3:0] cnt;
      bit ac;
      int phase_len;
      none = '0;
      reset = 1;
      start = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = msp_pkg::REG_MIN_PULSE;
      csr_data = '0;
      pulse_min = msp_pkg::DEFAULT_MINPW;
      chan_count = msp_pkg::DEFAULT_COUNT;
      lag_fix = 0;
      for (int i = 0; i < NCH; i++) begin
         ch_active[i] = 0; ch_high[i] = 0; ch_counted[i] = 0;
         ch_period[i] = 0; ch_left[i] = 0; ch_rise[i] = 0; ch_fall[i] = 0;
         ch_crise[i] = 0; ch_lag[i] = 0; ch_cap[i] = 0;
         ch_floor[i] = msp_pkg::DEFAULT_FLOOR;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part: reset state, short interval, wrap of time, zero-step start.
      add_row(msp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1,
              '{8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0});
      add_row(msp_pkg::OP_START, 0, 0, 19, 2, 1, 1,
              '{8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 32'd0});
      add_row(msp_pkg::OP_START, 0, 100, 20, 2, 1);
      add_row(msp_pkg::OP_TICK, 0, 120, 0, 0, 0);
      add_row(msp_pkg::OP_TICK, 0, 130, 0, 0, 0);
      add_row(msp_pkg::OP_TICK, 0, 160, 0, 0, 0);
      add_row(msp_pkg::OP_START, 7, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      add_row(msp_pkg::OP_START, 1, 32'hFFFF_FFF0, 40, 32'hFFFF_FFFF, 1);
      add_row(msp_pkg::OP_TICK, 0, 32'h0000_0030, 0, 0, 0);
      add_row(msp_pkg::OP_TICK, 0, 32'h0000_0040, 0, 0, 0);
      add_row(msp_pkg::OP_PAUSE, 1, 0, 0, 0, 0);
      add_row(msp_pkg::OP_QUERY, 1, 0, 0, 0, 0);
      add_row(msp_pkg::OP_RESUME, 1, 200, 0, 0, 0);
      add_row(msp_pkg::OP_STOP, 1, 0, 0, 0, 0);
      add_row(msp_pkg::OP_TICK, 0, 260, 0, 0, 0);
      add_row(msp_pkg::OP_SET_IVL, 2, 0, 5, 0, 0);
      add_row(msp_pkg::OP_SET_IVL, 2, 0, 50, 0, 0);
      add_row(msp_pkg::OP_SET_MIN, 3, 0, 40, 0, 0);
      add_row(msp_pkg::OP_SET_MIN, 3, 0, 3, 0, 0);
      add_row(msp_pkg::OP_START, 4, 300, 30, 0, 1);
      add_row(msp_pkg::OP_TICK, 0, 300, 0, 0, 0);
      add_row(msp_pkg::OP_TICK, 0, 310, 0, 0, 0);
      add_row(msp_pkg::OP_QUERY, 7, 0, 0, 0, 0);
      foreach (directed_rows[k])
         send_request(directed_rows[k].r, $urandom_range(0, 3), directed_rows[k].typed,
                      directed_rows[k].exp);
      clock_now = 400;

      // Random part in phases, each with its own register setting.
      for (int ph = 0; ph < 14; ph++) begin
         drain();
         case (ph)
            0: begin pw = 10; cnt = 8; ac = 1; end
            1: begin pw = 0; cnt = 8; ac = 0; end
            2: begin pw = 32'hFFFF_FFFF; cnt = 8; ac = 0; end
            3: begin pw = 4; cnt = 0; ac = 1; end
            4: begin pw = 5; cnt = 15; ac = 1; end
            5: begin pw = 2; cnt = 3; ac = 0; end
            default: begin
               pw = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 15);
               cnt = 4'($urandom_range(0, 15));
               ac = 1'($urandom_range(0, 1));
            end
         endcase
         if (ph == 2) phase_len = 30;
         else phase_len = 140;
         write_register(msp_pkg::REG_MIN_PULSE, pw);
         write_register(msp_pkg::REG_MOTOR_CNT, {28'd0, cnt});
         write_register(msp_pkg::REG_AUTOCORR, 32'(ac));
         for (int k = 0; k < phase_len; k++) begin
            // Re-enable lag correction mid-run so running channels get their copy.
            if (ac && k == phase_len / 2) begin
               drain();
               write_register(msp_pkg::REG_AUTOCORR, 32'd0);
               write_register(msp_pkg::REG_AUTOCORR, 32'd1);
            end
            // One mid-phase hold-off until the block has answered everything.
            if (ph == 7 && k == 60) drain();
            send_request(random_request(),
                         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13), 0, none);
         end
      end

      drain();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
